// ----- src/otsp_pkg.sv -----
// ----------------------------------------------------------------------------
// otsp_pkg
// Shared types and constants for the one-shot timer slot pool.
// ----------------------------------------------------------------------------
package otsp_pkg;

    localparam int NUM_SLOTS = 48;
    localparam int STEP_W    = $clog2(NUM_SLOTS + 1);
    localparam int CMD_W     = 3;
    localparam int IDX_W     = 8;
    localparam int SLOT_W    = 6;
    localparam int CNT_W     = 32;
    localparam int HDL_W     = 32;
    localparam int IN_W      = 80;
    localparam int OUT_W     = 40;

    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

    typedef struct packed {
        logic             taken;
        logic             armed;
        logic [CNT_W-1:0] counter;
        logic [HDL_W-1:0] handler;
    } t_slot;

    typedef struct packed {
        logic fire;
        logic alloc_hit;
        logic idle;
    } t_head_stat;

    typedef struct packed {
        logic              is_fire;
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic              idle;
        logic [HDL_W-1:0]  handler;
        logic              last;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// ----- src/otsp_cell.sv -----
// ----------------------------------------------------------------------------
// otsp_cell
// One timer slot of the ring; takes its neighbor's slot on every shift.
// ----------------------------------------------------------------------------
module otsp_cell
    import otsp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_slot i_slot,
    output t_slot o_slot
);

    t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_shift) begin
            r_slot <= i_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

// ----- src/otsp_head.sv -----
// ----------------------------------------------------------------------------
// otsp_head
// Applies the current command to the slot at the head of the ring.
// ----------------------------------------------------------------------------
module otsp_head
    import otsp_pkg::*;
(
    input  t_slot            i_slot,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic             i_match,
    input  logic             i_alloc_open,
    input  logic [CNT_W-1:0] i_tick_count,
    input  logic [HDL_W-1:0] i_handler_id,
    output t_slot            o_slot,
    output t_head_stat       o_stat
);

    logic [CNT_W-1:0] w_dec;

    assign w_dec = (i_slot.counter != '0) ? i_slot.counter - 1'b1 : i_slot.counter;

    always_comb begin
        o_slot = i_slot;
        o_stat = '0;
        case (i_cmd)
            CMD_TICK: begin
                if (i_slot.armed) begin
                    o_slot.counter = w_dec;
                    o_stat.fire    = (w_dec == CNT_W'(1)) && (i_slot.handler != '0);
                end
            end
            CMD_ALLOC: begin
                if (!i_slot.taken && i_alloc_open) begin
                    o_slot.taken     = 1'b1;
                    o_slot.counter   = '0;
                    o_slot.handler   = '0;
                    o_stat.alloc_hit = 1'b1;
                end
            end
            CMD_RELEASE: begin
                if (i_match) begin
                    o_slot = '0;
                end
            end
            CMD_START: begin
                if (i_match) begin
                    o_slot.counter = i_tick_count;
                    o_slot.handler = i_handler_id;
                    o_slot.armed   = 1'b1;
                end
            end
            CMD_QUERY: begin
                o_stat.idle = i_match && (i_slot.counter == '0);
            end
            default: begin
                o_slot = i_slot;
            end
        endcase
    end

endmodule

// ----- src/one_shot_timer_slot_pool.sv -----
// ----------------------------------------------------------------------------
// one_shot_timer_slot_pool
// Pool of one-shot timer slots kept in a rotating ring of cells.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries one command: tick, allocate,
// release, start or query idle. The slots sit in a ring of cells that
// rotates by one position per cycle unless stalled; the slot at the head
// is updated by the command and fed back into the tail, so a full pass
// visits every slot in ascending order and restores the ring.
// A request is taken only while the block is idle. It then makes one
// full pass and a closing step before the block is idle again, so a new
// request is not taken before the last one is through. Commands other
// than tick give one reply with tlast set at the end of the pass. A tick
// gives one fire event per firing slot in slot order, tuser high, tlast
// on the final one, and no event at all when nothing fires. A registered
// output stage holds each result until it is taken; while it is full and
// a further fire is found, the ring stops rotating until the receiver
// takes the waiting result.
// Reset clears every slot and the control state.
// ----------------------------------------------------------------------------
module one_shot_timer_slot_pool
    import otsp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // cmd[2:0], slot_index[10:3], tick_count[42:11], handler_id[74:43], zero fill
    input  logic [IN_W-1:0] s_axis_tdata,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // ok[0], result_slot[6:1], idle[7], fire_handler[39:8]
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic            m_axis_tlast,
    // is_fire[0]
    output logic            m_axis_tuser
);

    t_state            r_state;
    t_state            n_state;
    logic [CMD_W-1:0]  r_cmd;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_ticks;
    logic [HDL_W-1:0]  r_hdl;
    logic [STEP_W-1:0] r_step;
    logic              r_found;
    logic [SLOT_W-1:0] r_found_slot;
    logic              r_idle;
    logic              r_pend_v;
    logic [SLOT_W-1:0] r_pend_slot;
    logic [HDL_W-1:0]  r_pend_hdl;
    logic              r_out_v;
    t_result           r_out;
    t_result           n_out;

    t_slot      w_cell [NUM_SLOTS];
    t_slot      w_head_new;
    t_head_stat w_stat;
    logic       w_accept;
    logic       w_out_free;
    logic       w_match;
    logic       w_idx_ok;
    logic       w_shift;
    logic       w_push;
    logic       w_finish;
    logic       w_last_step;

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_out_v || m_axis_tready;
    assign w_idx_ok    = r_idx < IDX_W'(NUM_SLOTS);
    assign w_match     = (IDX_W'(r_step) == r_idx);
    assign w_last_step = (r_step == STEP_W'(NUM_SLOTS - 1));

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++) begin : g_ring
            if (g == NUM_SLOTS - 1) begin : g_tail
                otsp_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_slot  (w_head_new),
                    .o_slot  (w_cell[g])
                );
            end else begin : g_body
                otsp_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_slot  (w_cell[g+1]),
                    .o_slot  (w_cell[g])
                );
            end
        end
    endgenerate

    otsp_head u_head (
        .i_slot       (w_cell[0]),
        .i_cmd        (r_cmd),
        .i_match      (w_match),
        .i_alloc_open (!r_found),
        .i_tick_count (r_ticks),
        .i_handler_id (r_hdl),
        .o_slot       (w_head_new),
        .o_stat       (w_stat)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_shift && w_last_step) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_shift       = 1'b0;
        w_push        = 1'b0;
        w_finish      = 1'b0;
        n_out         = '0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_SCAN: begin
                w_shift = !(w_stat.fire && r_pend_v && !w_out_free);
                if (w_shift && w_stat.fire && r_pend_v) begin
                    w_push          = 1'b1;
                    n_out.is_fire   = 1'b1;
                    n_out.ok        = 1'b1;
                    n_out.slot      = r_pend_slot;
                    n_out.handler   = r_pend_hdl;
                end
            end
            S_DONE: begin
                if (r_cmd == CMD_TICK) begin
                    if (r_pend_v) begin
                        w_finish      = w_out_free;
                        w_push        = w_out_free;
                        n_out.is_fire = 1'b1;
                        n_out.ok      = 1'b1;
                        n_out.slot    = r_pend_slot;
                        n_out.handler = r_pend_hdl;
                        n_out.last    = 1'b1;
                    end else begin
                        w_finish = 1'b1;
                    end
                end else begin
                    w_finish   = w_out_free;
                    w_push     = w_out_free;
                    n_out.last = 1'b1;
                    case (r_cmd)
                        CMD_ALLOC: begin
                            n_out.ok   = r_found;
                            n_out.slot = r_found ? r_found_slot : '0;
                        end
                        CMD_RELEASE, CMD_START: begin
                            n_out.ok = w_idx_ok;
                        end
                        CMD_QUERY: begin
                            n_out.ok   = w_idx_ok;
                            n_out.idle = r_idle;
                        end
                        default: begin
                            n_out.ok = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_found  <= 1'b0;
            r_idle   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_step  <= '0;
                r_found <= 1'b0;
                r_idle  <= 1'b0;
            end else if (w_shift) begin
                r_step <= r_step + 1'b1;
                if (w_stat.alloc_hit) begin
                    r_found <= 1'b1;
                end
                if (w_stat.idle) begin
                    r_idle <= 1'b1;
                end
            end
            if (w_shift && w_stat.fire) begin
                r_pend_v <= 1'b1;
            end else if (w_finish) begin
                r_pend_v <= 1'b0;
            end
            if (w_push) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= s_axis_tdata[2:0];
            r_idx   <= s_axis_tdata[10:3];
            r_ticks <= s_axis_tdata[42:11];
            r_hdl   <= s_axis_tdata[74:43];
        end
        if (w_shift && w_stat.alloc_hit) begin
            r_found_slot <= SLOT_W'(r_step);
        end
        if (w_shift && w_stat.fire) begin
            r_pend_slot <= SLOT_W'(r_step);
            r_pend_hdl  <= w_cell[0].handler;
        end
        if (w_push) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {r_out.handler, r_out.idle, r_out.slot, r_out.ok};
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tuser  = r_out.is_fire;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_step < STEP_W'(NUM_SLOTS)))
        else $error("ring position ran past the last slot");

    a_pass_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_state == S_DONE) |-> w_last_step)
        else $error("pass ended before the ring came back to its start");

    a_pend_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_cmd == CMD_TICK))
        else $error("fire event pending outside a tick");

    a_accept_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !r_pend_v)
        else $error("new request taken while a fire event is still pending");

    a_found_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_found) |-> (r_cmd == CMD_ALLOC))
        else $error("free slot recorded outside an allocate");

endmodule
